### src/pcf_pkg.sv
// shared types and constants for the projector command framer
package pcf_pkg;

    // input mode codes
    localparam logic [1:0] MODE_SET = 2'd0;
    localparam logic [1:0] MODE_GET = 2'd1;
    localparam logic [1:0] MODE_RX  = 2'd2;

    // frame and protocol bytes
    localparam logic [7:0] BYTE_START   = 8'h1B;
    localparam logic [7:0] BYTE_SET_LEN = 8'h07;
    localparam logic [7:0] BYTE_SET_CMD = 8'h01;
    localparam logic [7:0] BYTE_GET_LEN = 8'h06;
    localparam logic [7:0] BYTE_GET_CMD = 8'h02;
    localparam logic [7:0] BYTE_ACK     = 8'h06;

    // reply tracker positions
    localparam logic [3:0] POS_SET_CHECK = 4'd5;
    localparam logic [3:0] POS_GET_CHECK = 4'd7;
    localparam logic [3:0] POS_CAPTURE   = 4'd6;
    localparam logic [3:0] POS_MAX       = 4'd15;

    // final beat index of each frame
    localparam logic [2:0] IDX_SET_LAST = 3'd6;
    localparam logic [2:0] IDX_GET_LAST = 3'd5;

    typedef enum logic [1:0] {
        JOB_SET,
        JOB_GET,
        JOB_REPLY
    } job_kind_t;

    // one classified item between front and back
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  type_hi;
        logic [7:0]  type_lo;
        logic [7:0]  value;     // set value, or reported reply value
        logic [7:0]  check;     // frame checksum for commands
        logic        done;
        logic        ok;
    } job_t;

endpackage

### src/projector_command_framer.sv
// top level of the projector command framer
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | mode, setting_type, setting_value, rx_byte
//  out     | out_valid / out_ready| tx_valid, tx_byte, last, reply_done,
//          |                      | reply_ok, reply_value
//
// an input beat is taken every cycle while the job queue has room; mode three
// is dropped. a set command plays out 7 output beats, a get 6, a received
// byte 1, one per cycle from the output register while the output is not
// stalled. the reply tracker sits in the front end and is updated at accept.
// output stalls fill the queue before in_ready drops. reset clears the
// tracker, the queue pointers and the output valid.
module projector_command_framer
    import pcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] setting_type,
    input  logic [7:0]  setting_value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic        reply_done,
    output logic        reply_ok,
    output logic [7:0]  reply_value
);

    logic push, pop, queue_full, queue_empty;
    job_t push_data, pop_data;

    // accept and classify
    pcf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .setting_type  (setting_type),
        .setting_value (setting_value),
        .rx_byte       (rx_byte),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data)
    );

    // job queue
    pcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // byte playout
    pcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .job         (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .last        (last),
        .reply_done  (reply_done),
        .reply_ok    (reply_ok),
        .reply_value (reply_value)
    );

endmodule

### src/pcf_front.sv
// front end: accepts beats, tracks replies and builds jobs for the back end
module pcf_front
    import pcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] setting_type,
    input  logic [7:0]  setting_value,
    input  logic [7:0]  rx_byte,
    input  logic        queue_full,
    output logic        push,
    output job_t        push_data
);

    logic       awaiting_get_reg, awaiting_get_next;
    logic [3:0] position_reg, position_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] captured_reg, captured_next;

    logic       accept;
    logic       is_cmd;
    logic [3:0] pos_base;
    logic [7:0] sum_base;
    logic [7:0] sum_neg;
    logic [3:0] target;
    logic       done;
    logic       ok;
    logic [7:0] cmd_sum;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_cmd   = (mode == MODE_SET) || (mode == MODE_GET);

    // reply parsing of one received byte
    always_comb
    begin
        pos_base = (rx_byte == BYTE_START) ? '0 : position_reg;
        sum_base = (rx_byte == BYTE_START) ? '0 : sum_reg;
        sum_neg  = 8'd0 - sum_base;
        target   = awaiting_get_reg ? POS_GET_CHECK : POS_SET_CHECK;
        done     = (pos_base == target);
        ok       = done && (rx_byte == sum_neg);
    end

    // frame checksum over the bytes after the start byte
    always_comb
    begin
        if (mode == MODE_SET)
            cmd_sum = BYTE_SET_LEN + BYTE_SET_CMD + setting_type[15:8]
                      + setting_type[7:0] + setting_value;
        else
            cmd_sum = BYTE_GET_LEN + BYTE_GET_CMD + setting_type[15:8]
                      + setting_type[7:0];
    end

    // tracker next state and job build
    always_comb
    begin
        awaiting_get_next = awaiting_get_reg;
        position_next     = position_reg;
        sum_next          = sum_reg;
        captured_next     = captured_reg;
        push              = 1'b0;
        push_data.kind    = JOB_REPLY;
        push_data.type_hi = setting_type[15:8];
        push_data.type_lo = setting_type[7:0];
        push_data.value   = setting_value;
        push_data.check   = 8'd0 - cmd_sum;
        push_data.done    = 1'b0;
        push_data.ok      = 1'b0;
        if (accept && is_cmd)
        begin
            awaiting_get_next = (mode == MODE_GET);
            position_next     = '0;
            sum_next          = '0;
            captured_next     = '0;
            push              = 1'b1;
            push_data.kind    = (mode == MODE_GET) ? JOB_GET : JOB_SET;
        end
        else if (accept && mode == MODE_RX)
        begin
            sum_next = done ? sum_neg : sum_base + rx_byte;
            if (awaiting_get_reg && pos_base == POS_CAPTURE)
                captured_next = rx_byte;
            position_next   = (pos_base < POS_MAX) ? pos_base + 4'd1 : pos_base;
            push            = 1'b1;
            push_data.kind  = JOB_REPLY;
            push_data.done  = done;
            push_data.ok    = ok;
            push_data.value = (done && awaiting_get_reg) ? captured_reg : 8'd0;
        end
    end

    // tracker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_get_reg <= 1'b0;
            position_reg     <= '0;
            sum_reg          <= '0;
            captured_reg     <= '0;
        end
        else
        begin
            awaiting_get_reg <= awaiting_get_next;
            position_reg     <= position_next;
            sum_reg          <= sum_next;
            captured_reg     <= captured_next;
        end
    end

endmodule

### src/pcf_queue.sv
// short job queue between front and back end
module pcf_queue
    import pcf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### src/pcf_back.sv
// back end: plays out frame bytes and reply results into the output register
module pcf_back
    import pcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_empty,
    input  job_t       job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       last,
    output logic       reply_done,
    output logic       reply_ok,
    output logic [7:0] reply_value
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       ok_reg, ok_next;
    logic [7:0] value_reg, value_next;

    logic       load;
    logic       final_beat;
    logic [7:0] frame_byte;

    assign load = !queue_empty && (!out_valid_reg || out_ready);

    // frame byte select and end of job
    always_comb
    begin
        case (job.kind)
            JOB_SET:   final_beat = (idx_reg == IDX_SET_LAST);
            JOB_GET:   final_beat = (idx_reg == IDX_GET_LAST);
            default:   final_beat = 1'b1;
        endcase
        case (idx_reg)
            3'd0:    frame_byte = BYTE_START;
            3'd1:    frame_byte = (job.kind == JOB_GET) ? BYTE_GET_LEN : BYTE_SET_LEN;
            3'd2:    frame_byte = (job.kind == JOB_GET) ? BYTE_GET_CMD : BYTE_SET_CMD;
            3'd3:    frame_byte = job.type_hi;
            3'd4:    frame_byte = job.type_lo;
            3'd5:    frame_byte = (job.kind == JOB_GET) ? job.check : job.value;
            default: frame_byte = job.check;
        endcase
    end

    assign pop = load && final_beat;

    // output register load
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        ok_next        = ok_reg;
        value_next     = value_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = final_beat ? '0 : idx_reg + 3'd1;
            last_next      = final_beat;
            if (job.kind == JOB_REPLY)
            begin
                tx_valid_next = job.ok;
                tx_byte_next  = job.ok ? BYTE_ACK : 8'd0;
                done_next     = job.done;
                ok_next       = job.ok;
                value_next    = job.value;
            end
            else
            begin
                tx_valid_next = 1'b1;
                tx_byte_next  = frame_byte;
                done_next     = 1'b0;
                ok_next       = 1'b0;
                value_next    = 8'd0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        tx_valid_reg <= tx_valid_next;
        tx_byte_reg  <= tx_byte_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
        ok_reg       <= ok_next;
        value_reg    <= value_next;
    end

    assign out_valid   = out_valid_reg;
    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign last        = last_reg;
    assign reply_done  = done_reg;
    assign reply_ok    = ok_reg;
    assign reply_value = value_reg;

endmodule

### tb/projector_command_framer_tb.sv
// self-checking testbench for the projector command framer
`timescale 1ns / 1ps

module projector_command_framer_tb;
    import pcf_pkg::*;

    // mode value the block drops without a result
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int TOTAL_ITEMS = 460;
    localparam int LONG_HOLD = 250;
    localparam int HOLD_AT_ITEM = 60;
    localparam int DRAIN_AT_ITEM = 300;
    localparam int TAIL_CYCLES = 40;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECK,
        FLAW_SHORT,
        FLAW_RESTART
    } flaw_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] stype;
        logic [7:0]  sval;
        logic [7:0]  rx;
    } cmd_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic        done;
        logic        ok;
        logic [7:0]  value;
    } out_beat_t;

    typedef struct packed {
        cmd_item_t   item;
        logic        typed;
        out_beat_t   want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [15:0] setting_type;
    logic [7:0]  setting_value;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        reply_done;
    logic        reply_ok;
    logic [7:0]  reply_value;

    // reply tracker mirror
    logic        trk_get;
    logic [3:0]  trk_pos;
    logic [7:0]  trk_sum;
    logic [7:0]  trk_capture;

    out_beat_t   frame_beats_due[$];
    stim_row_t   directed_rows[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;

    projector_command_framer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .setting_type  (setting_type),
        .setting_value (setting_value),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .last          (last),
        .reply_done    (reply_done),
        .reply_ok      (reply_ok),
        .reply_value   (reply_value)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // beats that one accepted item must produce, tracker updated in step
    function automatic void frame_and_track(input cmd_item_t it);
        logic [7:0] fb [6];
        logic [7:0] sum;
        logic [3:0] chk_pos;
        out_beat_t  b;
        int         n;
        int         i;
        case (it.mode)
            MODE_SET, MODE_GET:
            begin
                trk_get = (it.mode == MODE_GET);
                trk_pos = 4'd0;
                trk_sum = 8'h00;
                trk_capture = 8'h00;
                fb[0] = BYTE_START;
                fb[3] = it.stype[15:8];
                fb[4] = it.stype[7:0];
                fb[5] = it.sval;
                if (it.mode == MODE_SET)
                begin
                    fb[1] = BYTE_SET_LEN;
                    fb[2] = BYTE_SET_CMD;
                    n = 6;
                end
                else
                begin
                    fb[1] = BYTE_GET_LEN;
                    fb[2] = BYTE_GET_CMD;
                    n = 5;
                end
                sum = 8'h00;
                for (i = 0; i < n; i++)
                begin
                    frame_beats_due.push_back('{1'b1, fb[i], 1'b0, 1'b0, 1'b0, 8'h00});
                    if (i > 0)
                        sum = sum + fb[i];
                end
                frame_beats_due.push_back('{1'b1, 8'h00 - sum, 1'b1, 1'b0, 1'b0, 8'h00});
            end
            MODE_RX:
            begin
                chk_pos = trk_get ? POS_GET_CHECK : POS_SET_CHECK;
                if (it.rx == BYTE_START)
                begin
                    trk_pos = 4'd0;
                    trk_sum = 8'h00;
                end
                b = '0;
                b.last = 1'b1;
                b.done = (trk_pos == chk_pos);
                if (!b.done)
                    trk_sum = trk_sum + it.rx;
                if (trk_get && trk_pos == POS_CAPTURE)
                    trk_capture = it.rx;
                if (b.done)
                begin
                    trk_sum = 8'h00 - trk_sum;
                    b.ok = (it.rx == trk_sum);
                    if (b.ok)
                    begin
                        b.tx_valid = 1'b1;
                        b.tx_byte = BYTE_ACK;
                    end
                    if (trk_get)
                        b.value = trk_capture;
                end
                if (trk_pos != POS_MAX)
                    trk_pos = trk_pos + 4'd1;
                frame_beats_due.push_back(b);
            end
            default:
            begin
                // dropped, no beat and no state change
            end
        endcase
    endfunction

    function automatic stim_row_t plain_row(input logic [1:0] m, input logic [15:0] t,
                                            input logic [7:0] v, input logic [7:0] r);
        plain_row = '{'{m, t, v, r}, 1'b0, '0};
    endfunction

    function automatic stim_row_t rx_row_with(input logic [7:0] r, input out_beat_t w);
        rx_row_with = '{'{MODE_RX, 16'h0000, 8'h00, r}, 1'b1, w};
    endfunction

    function automatic out_beat_t reply_beat(input logic tv, input logic [7:0] b,
                                             input logic d, input logic k,
                                             input logic [7:0] v);
        reply_beat = '{tv, b, 1'b1, d, k, v};
    endfunction

    function automatic cmd_item_t random_fields();
        random_fields = '{2'($urandom_range(3)), 16'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    function automatic logic [7:0] any_but_start();
        any_but_start = 8'($urandom);
        if (any_but_start == BYTE_START)
            any_but_start = 8'h00;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // offer one input beat, with random idle cycles ahead of it
    task automatic drive_item(input cmd_item_t it, input logic typed, input out_beat_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_and_track(it);
        if (typed)
        begin
            void'(frame_beats_due.pop_back());
            frame_beats_due.push_back(want);
        end
        if (it.mode != MODE_NONE)
            items_sent++;
        in_valid      <= 1'b1;
        mode          <= it.mode;
        setting_type  <= it.stype;
        setting_value <= it.sval;
        rx_byte       <= it.rx;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_rx(input logic [7:0] b);
        cmd_item_t it;
        it = random_fields();
        it.mode = MODE_RX;
        it.rx = b;
        drive_item(it, 1'b0, '0);
    endtask

    task automatic send_command(input logic as_get);
        cmd_item_t it;
        it = random_fields();
        it.mode = as_get ? MODE_GET : MODE_SET;
        drive_item(it, 1'b0, '0);
    endtask

    // reply frame with a correct checksum, optionally spoiled
    task automatic send_reply(input logic as_get, input flaw_t flaw);
        logic [7:0] body [8];
        logic [7:0] sum;
        int         len;
        int         i;
        len = as_get ? 8 : 6;
        body[0] = BYTE_START;
        sum = BYTE_START;
        for (i = 1; i < len - 1; i++)
        begin
            body[i] = any_but_start();
            sum = sum + body[i];
        end
        body[len - 1] = 8'h00 - sum;
        case (flaw)
            FLAW_CHECK:   body[len - 1] = body[len - 1] ^ 8'($urandom_range(255, 1));
            FLAW_SHORT:   len = $urandom_range(len - 1, 1);
            FLAW_RESTART: body[$urandom_range(len - 1, 1)] = BYTE_START;
            default:      ;
        endcase
        for (i = 0; i < len; i++)
            send_rx(body[i]);
    endtask

    // stop offering until every expected beat has come out
    task automatic settle_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (frame_beats_due.size() != 0);
    endtask

    // output side ready, with random stalls and one long hold-off
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare every output beat with the oldest expected one
    always @(posedge clk)
    begin : watch_out
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_beats_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual %h", $time,
                         {tx_valid, tx_byte, last, reply_done, reply_ok, reply_value});
            end
            else
            begin
                want = frame_beats_due.pop_front();
                check_field("tx_valid", want.tx_valid, tx_valid);
                check_field("tx_byte", want.tx_byte, tx_byte);
                check_field("last", want.last, last);
                check_field("reply_done", want.done, reply_done);
                check_field("reply_ok", want.ok, reply_ok);
                check_field("reply_value", want.value, reply_value);
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int   pick;
        int   k;
        logic as_get;
        bit   hold_done;
        bit   drain_done;
        cmd_item_t it;

        hold_done = 1'b0;
        drain_done = 1'b0;
        trk_get = 1'b0;
        trk_pos = 4'd0;
        trk_sum = 8'h00;
        trk_capture = 8'h00;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        mode          <= MODE_SET;
        setting_type  <= 16'h0000;
        setting_value <= 8'h00;
        rx_byte       <= 8'h00;

        // mode three with every bit set is dropped
        directed_rows.push_back(plain_row(MODE_NONE, 16'hFFFF, 8'hFF, 8'hFF));
        // reply before any command parses as a set reply
        directed_rows.push_back(rx_row_with(BYTE_START, reply_beat(1'b0, 8'h00, 1'b0, 1'b0, 8'h00)));
        repeat (4) directed_rows.push_back(plain_row(MODE_RX, 16'hFFFF, 8'hFF, 8'h00));
        directed_rows.push_back(rx_row_with(8'hE5, reply_beat(1'b1, BYTE_ACK, 1'b1, 1'b1, 8'h00)));
        // get with all-zero type and a good reply
        directed_rows.push_back(plain_row(MODE_GET, 16'h0000, 8'h00, 8'h00));
        directed_rows.push_back(plain_row(MODE_RX, 16'h0000, 8'h00, BYTE_START));
        directed_rows.push_back(plain_row(MODE_RX, 16'h0000, 8'h00, 8'h06));
        directed_rows.push_back(plain_row(MODE_RX, 16'h0000, 8'h00, 8'h02));
        repeat (3) directed_rows.push_back(plain_row(MODE_RX, 16'h0000, 8'h00, 8'h00));
        directed_rows.push_back(plain_row(MODE_RX, 16'h0000, 8'h00, 8'h5A));
        directed_rows.push_back(rx_row_with(8'h83, reply_beat(1'b1, BYTE_ACK, 1'b1, 1'b1, 8'h5A)));
        // byte past the checksum position
        directed_rows.push_back(rx_row_with(8'h83, reply_beat(1'b0, 8'h00, 1'b0, 1'b0, 8'h00)));
        // get with a bad reply checksum still reports the value
        directed_rows.push_back(plain_row(MODE_GET, 16'hFFFF, 8'h00, 8'h00));
        directed_rows.push_back(plain_row(MODE_RX, 16'hFFFF, 8'hFF, BYTE_START));
        repeat (5) directed_rows.push_back(plain_row(MODE_RX, 16'hFFFF, 8'hFF, 8'hFF));
        directed_rows.push_back(plain_row(MODE_RX, 16'hFFFF, 8'hFF, 8'h5A));
        directed_rows.push_back(rx_row_with(8'h00, reply_beat(1'b0, 8'h00, 1'b1, 1'b0, 8'h5A)));
        // set commands at the field extremes
        directed_rows.push_back(plain_row(MODE_SET, 16'hFFFF, 8'hFF, 8'hFF));
        directed_rows.push_back(plain_row(MODE_SET, 16'h0000, 8'h00, 8'h00));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        for (k = 0; k < directed_rows.size(); k++)
            drive_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        settle_outputs();

        // random part, mostly well-formed exchanges
        while (items_sent < TOTAL_ITEMS)
        begin
            case (items_sent / 115)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 53; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            // long output hold-off while input keeps coming
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            if (!drain_done && items_sent >= DRAIN_AT_ITEM)
            begin
                drain_done = 1'b1;
                settle_outputs();
            end
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                as_get = 1'($urandom_range(1));
                send_command(as_get);
                send_reply(as_get, FLAW_NONE);
                repeat ($urandom_range(2)) send_rx(8'($urandom));
            end
            else if (pick < 55)
                send_reply(trk_get, FLAW_NONE);
            else if (pick < 70)
                send_reply(1'($urandom_range(1)), flaw_t'($urandom_range(3, 1)));
            else if (pick < 80)
            begin
                // long run without a start byte can saturate the position
                repeat ($urandom_range(24, 10)) send_rx(any_but_start());
            end
            else if (pick < 92)
            begin
                it = random_fields();
                drive_item(it, 1'b0, '0);
            end
            else
                send_command(1'($urandom_range(1)));
        end

        settle_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
src/pcf_pkg.sv
src/pcf_front.sv
src/pcf_queue.sv
src/pcf_back.sv
src/projector_command_framer.sv
tb/projector_command_framer_tb.sv
